[rtl/cwr_pkg.sv]
// Shared types and constants for the co-visibility weight ranker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cwr_pkg;
  localparam int unsigned IdW = 6;
  localparam int unsigned CountW = 16;
  localparam logic [CountW-1:0] CountMax = 16'hFFFF;
  localparam logic [CountW-1:0] ResetMinWeight = 16'd15;
  localparam int unsigned AddrW = 3;
  localparam logic [AddrW-1:0] RegSelfId = 3'd0;
  localparam logic [AddrW-1:0] RegMinWeight = 3'd4;

  typedef struct packed {
    logic          count;
    logic          take;
    logic          clear;
    logic [IdW-1:0] id;
  } cell_ctrl_t;
endpackage
`default_nettype wire

[rtl/cwr_cell.sv]
// One count cell of the ranker chain: holds a keyframe weight, registers the
// rank-max candidate and hands it to the next cell every cycle. Uses cwr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cwr_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [cwr_pkg::IdW-1:0]       my_id_i,
  input  cwr_pkg::cell_ctrl_t           ctrl_i,
  input  logic                          cand_v_i,
  input  logic [cwr_pkg::IdW-1:0]       cand_id_i,
  input  logic [cwr_pkg::CountW-1:0]    cand_w_i,
  output logic                          cand_v_o,
  output logic [cwr_pkg::IdW-1:0]       cand_id_o,
  output logic [cwr_pkg::CountW-1:0]    cand_w_o
);
  import cwr_pkg::*;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              cv_q, cv_d;
  logic [IdW-1:0]    cid_q, cid_d;
  logic [CountW-1:0] cw_q, cw_d;
  logic              mine;

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_i.clear) begin
      cnt_d = '0;
    end else if (ctrl_i.take && ctrl_i.id == my_id_i) begin
      cnt_d = '0;
    end else if (ctrl_i.count && ctrl_i.id == my_id_i && cnt_q != CountMax) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  assign mine = cnt_q != '0 &&
                (!cand_v_i || cnt_q > cand_w_i || (cnt_q == cand_w_i && my_id_i > cand_id_i));
  assign cv_d  = cand_v_i || cnt_q != '0;
  assign cid_d = mine ? my_id_i : cand_id_i;
  assign cw_d  = mine ? cnt_q : cand_w_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      cv_q  <= 1'b0;
      cid_q <= '0;
      cw_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      cv_q  <= cv_d;
      cid_q <= cid_d;
      cw_q  <= cw_d;
    end
  end

  assign cand_v_o  = cv_q;
  assign cand_id_o = cid_q;
  assign cand_w_o  = cw_q;
endmodule
`default_nettype wire

[rtl/covisibility_weight_ranker.sv]
// Top level of the co-visibility weight ranker: APB registers, sequencer and cell chain.
// Uses cwr_pkg and cwr_cell.
// Observation: a new transfer every cycle while no finish is running.
// Finish: input held; the chain is swept once per result plus a closing sweep,
// and the end of each sweep waits while the output stalls.
// Reset clears all counts, self_id to 0 and min_weight to 15.
`timescale 1ns / 1ps
`default_nettype none
module covisibility_weight_ranker #(
  parameter int unsigned KEYFRAMES = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cwr_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       mode_i,
  input  logic [cwr_pkg::IdW-1:0]    keyframe_id_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       valid_res_o,
  output logic [cwr_pkg::IdW-1:0]    neighbour_id_o,
  output logic [cwr_pkg::CountW-1:0] weight_o,
  output logic                       last_o
);
  import cwr_pkg::*;
  localparam int unsigned SwW = $clog2(KEYFRAMES + 1);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;

  logic [IdW-1:0]    self_id_q;
  logic [CountW-1:0] min_weight_q;
  logic [1:0]        st_q, st_d;
  logic [SwW-1:0]    sw_q, sw_d;
  logic              ov_q;
  logic              vr_q, last_q;
  logic [IdW-1:0]    nid_q;
  logic [CountW-1:0] w_q;
  logic              hv_q;
  logic [IdW-1:0]    hid_q;
  logic [CountW-1:0] hw_q;
  logic              in_acc, swept, emit, ok, slot, load;
  cell_ctrl_t        ctrl;
  logic                 cv [KEYFRAMES+1];
  logic [IdW-1:0]       ci [KEYFRAMES+1];
  logic [CountW-1:0]    cw [KEYFRAMES+1];

  assign pready = 1'b1;
  always_comb begin
    case (paddr)
      RegSelfId:    prdata = {26'd0, self_id_q};
      RegMinWeight: prdata = {16'd0, min_weight_q};
      default:      prdata = '0;
    endcase
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_id_q    <= '0;
      min_weight_q <= ResetMinWeight;
    end else if (psel && penable && pwrite) begin
      if (paddr == RegSelfId) self_id_q <= pwdata[IdW-1:0];
      if (paddr == RegMinWeight) min_weight_q <= pwdata[CountW-1:0];
    end
  end

  assign in_stall_o = st_q != StIdle;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign slot       = !ov_q || !out_stall_i;
  assign swept      = sw_q == SwW'(KEYFRAMES);
  assign ok         = cv[KEYFRAMES] && cw[KEYFRAMES] >= min_weight_q;
  assign emit       = st_q == StRun && swept && slot;
  assign load       = emit && (hv_q || !ok);

  always_comb begin
    ctrl.count = in_acc && !mode_i && keyframe_id_i != self_id_q;
    ctrl.take  = emit && ok;
    ctrl.clear = emit && !ok;
    ctrl.id    = (emit && ok) ? ci[KEYFRAMES] : keyframe_id_i;
    st_d = st_q;
    sw_d = sw_q;
    if (in_acc && mode_i) begin
      st_d = StRun;
      sw_d = '0;
    end else if (emit) begin
      sw_d = '0;
      if (!ok) st_d = StIdle;
    end else if (st_q == StRun && !swept) begin
      sw_d = sw_q + 1'b1;
    end
  end

  assign cv[0] = 1'b0;
  assign ci[0] = '0;
  assign cw[0] = '0;
  for (genvar g = 0; g < KEYFRAMES; g++) begin : g_cell
    cwr_cell u_cell (
      .clk_i, .rst_ni,
      .my_id_i(IdW'(g)), .ctrl_i(ctrl),
      .cand_v_i(cv[g]), .cand_id_i(ci[g]), .cand_w_i(cw[g]),
      .cand_v_o(cv[g+1]), .cand_id_o(ci[g+1]), .cand_w_o(cw[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StIdle;
      sw_q   <= '0;
      ov_q   <= 1'b0;
      hv_q   <= 1'b0;
      hid_q  <= '0;
      hw_q   <= '0;
      vr_q   <= 1'b0;
      nid_q  <= '0;
      w_q    <= '0;
      last_q <= 1'b0;
    end else begin
      st_q <= st_d;
      sw_q <= sw_d;
      if (load) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
      // hold one result back so that last can be set on the final one
      if (emit) begin
        hv_q  <= ok;
        hid_q <= ci[KEYFRAMES];
        hw_q  <= cw[KEYFRAMES];
      end
      if (load) begin
        vr_q   <= hv_q;
        nid_q  <= hv_q ? hid_q : '0;
        w_q    <= hv_q ? hw_q : '0;
        last_q <= !ok;
      end
    end
  end

  assign out_valid_o    = ov_q;
  assign valid_res_o    = vr_q;
  assign neighbour_id_o = nid_q;
  assign weight_o       = w_q;
  assign last_o         = last_q;

`ifndef ASSERT_OFF
  a_no_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StRun |-> in_stall_o) else $error("input taken during finish");
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> last_o) else $error("marker without last");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(ov_q && out_stall_i) |-> ov_q) else $error("result dropped");
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(ov_q && out_stall_i) |-> $stable({vr_q, nid_q, w_q, last_q}))
    else $error("stalled result changed");
`endif
endmodule
`default_nettype wire
